// ===== rtl/ctt_pkg.sv =====
// Shared widths, register indexes and sequencer states of the cubic trajectory tracker.
package ctt_pkg;

    // Field widths
    localparam int TIME_W    = 24;
    localparam int POS_W     = 32;
    localparam int KP_W      = 16;
    localparam int CFG_IDX_W = 2;

    // Serial multiplier: signed multiplicand, unsigned multiplier
    localparam int MCAND_W  = 34;
    localparam int MPLIER_W = 32;
    localparam int PROD_W   = MCAND_W + MPLIER_W;

    // Serial divider: unsigned dividend, divisor and quotient
    localparam int NUM_W = 66;
    localparam int DEN_W = 48;
    localparam int QUO_W = 32;

    // Normalised time u is unsigned Q1.30 and never exceeds one
    localparam int U_FRAC = 30;
    localparam int U_W    = 31;

    // Register reset values
    localparam logic [TIME_W-1:0] FINAL_TIME_RST = 24'h01_0000;
    localparam logic [KP_W-1:0]   KP_GAIN_RST    = 16'h0100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_POS  = 2'd0,
        CFG_TARGET_OFS = 2'd1,
        CFG_FINAL_TIME = 2'd2,
        CFG_KP_GAIN    = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_U,
        ST_MUL_U2,
        ST_MUL_U3,
        ST_MUL_P,
        ST_MUL_V,
        ST_DIV_V,
        ST_MUL_TT,
        ST_MUL_A,
        ST_DIV_A,
        ST_MUL_C,
        ST_LOAD
    } t_state;

endpackage

// ===== rtl/ctt_in_if.sv =====
// Request channel carrying one tick: elapsed time and measured position.
interface ctt_in_if;
    logic                            valid;
    logic                            ready;
    logic [ctt_pkg::TIME_W-1:0]      elapsed_time;
    logic signed [ctt_pkg::POS_W-1:0] measured_position;

    modport source (
        output valid, elapsed_time, measured_position,
        input  ready
    );

    modport sink (
        input  valid, elapsed_time, measured_position,
        output ready
    );
endinterface

// ===== rtl/ctt_out_if.sv =====
// Result channel carrying planned motion, velocity command and finished flag.
interface ctt_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ctt_pkg::POS_W-1:0] planned_position;
    logic signed [ctt_pkg::POS_W-1:0] planned_velocity;
    logic signed [ctt_pkg::POS_W-1:0] planned_acceleration;
    logic signed [ctt_pkg::POS_W-1:0] velocity_command;
    logic                             finished;

    modport source (
        output valid, planned_position, planned_velocity, planned_acceleration,
        output velocity_command, finished,
        input  ready
    );

    modport sink (
        input  valid, planned_position, planned_velocity, planned_acceleration,
        input  velocity_command, finished,
        output ready
    );
endinterface

// ===== rtl/ctt_mul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
module ctt_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ctt_pkg::MCAND_W-1:0]  i_mcand,
    input  logic [ctt_pkg::MPLIER_W-1:0]        i_mplier,
    output logic                                o_done,
    output logic signed [ctt_pkg::PROD_W-1:0]   o_prod
);

    localparam int CNT_W = $clog2(ctt_pkg::MPLIER_W);
    localparam int HI_W  = ctt_pkg::MCAND_W + 1;

    logic                              r_busy;
    logic                              r_done;
    logic [CNT_W-1:0]                  r_cnt;
    logic signed [ctt_pkg::MCAND_W-1:0] r_a;
    logic [HI_W-1:0]                   r_hi;
    logic [ctt_pkg::MPLIER_W-1:0]      r_lo;
    logic [HI_W-1:0]                   n_sum;

    // Add the multiplicand into the upper half when the current multiplier bit is set
    always_comb begin
        n_sum = r_hi + (r_lo[0] ? {r_a[ctt_pkg::MCAND_W-1], r_a} : HI_W'(0));
    end

    // Step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ctt_pkg::MPLIER_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift the partial product right one bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_mcand;
            r_hi <= '0;
            r_lo <= i_mplier;
        end else if (r_busy) begin
            r_hi <= {n_sum[HI_W-1], n_sum[HI_W-1:1]};
            r_lo <= {n_sum[0], r_lo[ctt_pkg::MPLIER_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[ctt_pkg::MCAND_W-1:0], r_lo};

endmodule

// ===== rtl/ctt_div.sv =====
// Bit-serial restoring divider with quotient overflow detection.
module ctt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ctt_pkg::NUM_W-1:0]     i_num,
    input  logic [ctt_pkg::DEN_W-1:0]     i_den,
    output logic                          o_done,
    output logic [ctt_pkg::QUO_W-1:0]     o_quo,
    output logic                          o_ovf
);

    localparam int CNT_W = $clog2(ctt_pkg::QUO_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [ctt_pkg::DEN_W-1:0]   r_rem;
    logic [ctt_pkg::DEN_W-1:0]   r_den;
    logic [ctt_pkg::QUO_W-1:0]   r_nlo;
    logic [ctt_pkg::QUO_W-1:0]   r_q;
    logic                        r_ovf;
    logic [ctt_pkg::DEN_W+1:0]   n_trial;
    logic                        n_borrow;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        n_trial  = {1'b0, r_rem, r_nlo[ctt_pkg::QUO_W-1]} - {2'b00, r_den};
        n_borrow = n_trial[ctt_pkg::DEN_W+1];
    end

    // Step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ctt_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Flag overflow when the upper dividend already reaches the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= ctt_pkg::DEN_W'(i_num[ctt_pkg::NUM_W-1:ctt_pkg::QUO_W]);
            r_ovf <= ctt_pkg::DEN_W'(i_num[ctt_pkg::NUM_W-1:ctt_pkg::QUO_W]) >= i_den;
            r_den <= i_den;
            r_nlo <= i_num[ctt_pkg::QUO_W-1:0];
            r_q   <= '0;
        end else if (r_busy) begin
            if (!n_borrow) begin
                r_rem <= n_trial[ctt_pkg::DEN_W-1:0];
            end else begin
                r_rem <= {r_rem[ctt_pkg::DEN_W-2:0], r_nlo[ctt_pkg::QUO_W-1]};
            end
            r_nlo <= {r_nlo[ctt_pkg::QUO_W-2:0], 1'b0};
            r_q   <= {r_q[ctt_pkg::QUO_W-2:0], ~n_borrow};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_ovf  = r_ovf;

endmodule

// ===== rtl/cubic_trajectory_tracker.sv =====
// Top level of the cubic rest-to-rest trajectory tracker for one axis.
//
//  channel   | dir | handshake         | contents
//  ----------+-----+-------------------+----------------------------------------------
//  i_in      | in  | valid / ready     | elapsed_time, measured_position
//  o_out     | out | valid / ready     | planned pos/vel/acc, velocity_command, finished
//  i_cfg_*   | in  | write enable only | register index, write data
//
// A moving tick makes ten passes through the shared bit-serial multiplier or divider
// between acceptance and a valid result.
// A finished tick (zero duration or time past the end) skips the passes and is loaded directly.
// Reset is synchronous and active low; it clears the held outputs and loads register defaults.
// A stalled result sits in the output register while the next request is already taken.
module cubic_trajectory_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ctt_in_if.sink                          i_in,
    ctt_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [ctt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ctt_pkg::POS_W-1:0]       i_cfg_data
);

    localparam int PW = ctt_pkg::POS_W;
    localparam int SW = 43;
    localparam logic [ctt_pkg::U_W+2:0] G_BASE = 34'd3 << ctt_pkg::U_FRAC;
    localparam logic signed [PW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PW-1:0] SAT_MIN = 32'sh8000_0000;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [PW-1:0] sat32(input logic signed [SW-1:0] x);
        logic [SW-PW:0] top;
        top = x[SW-1:PW-1];
        if ((&top) || !(|top)) begin
            return x[PW-1:0];
        end
        return x[SW-1] ? SAT_MIN : SAT_MAX;
    endfunction

    // Apply sign to a quotient magnitude, clamping on overflow
    function automatic logic signed [PW-1:0] sat_mag(input logic [ctt_pkg::QUO_W-1:0] q,
                                                      input logic ovf, input logic neg);
        if (neg) begin
            if (ovf || (q[ctt_pkg::QUO_W-1] && (|q[ctt_pkg::QUO_W-2:0]))) begin
                return SAT_MIN;
            end
            return PW'(ctt_pkg::QUO_W'(0) - q);
        end
        if (ovf || q[ctt_pkg::QUO_W-1]) begin
            return SAT_MAX;
        end
        return PW'(q);
    endfunction

    // Configuration registers
    logic signed [PW-1:0]               r_start_pos;
    logic signed [PW-1:0]               r_target_ofs;
    logic [ctt_pkg::TIME_W-1:0]         r_final_time;
    logic [ctt_pkg::KP_W-1:0]           r_kp;

    // Sequencer
    ctt_pkg::t_state                    r_state;
    ctt_pkg::t_state                    n_state;
    logic                               r_go;

    // Working registers
    logic [ctt_pkg::TIME_W-1:0]         r_t;
    logic signed [PW-1:0]               r_m;
    logic                               r_fin;
    logic [ctt_pkg::U_W-1:0]            r_u;
    logic [ctt_pkg::U_W-1:0]            r_u2;
    logic [ctt_pkg::U_W-1:0]            r_u3;
    logic [ctt_pkg::DEN_W-1:0]          r_tt;
    logic signed [PW-1:0]               r_p;
    logic signed [PW-1:0]               r_v;
    logic signed [PW-1:0]               r_a;
    logic signed [PW-1:0]               r_c;

    // Output register, which also holds the last motion outputs
    logic                               r_ov;
    logic signed [PW-1:0]               r_o_pos;
    logic signed [PW-1:0]               r_o_vel;
    logic signed [PW-1:0]               r_o_acc;
    logic signed [PW-1:0]               r_o_cmd;
    logic                               r_o_fin;

    // Handshake and unit control
    logic                               in_ready;
    logic                               accept;
    logic                               fin_now;
    logic                               load;
    logic                               mul_start;
    logic signed [ctt_pkg::MCAND_W-1:0] mul_mcand;
    logic [ctt_pkg::MPLIER_W-1:0]       mul_mplier;
    logic                               mul_done;
    logic signed [ctt_pkg::PROD_W-1:0]  mul_prod;
    logic                               div_start;
    logic [ctt_pkg::NUM_W-1:0]          div_num;
    logic [ctt_pkg::DEN_W-1:0]          div_den;
    logic                               div_done;
    logic [ctt_pkg::QUO_W-1:0]          div_quo;
    logic                               div_ovf;

    // Derived operands
    logic [PW-1:0]                      d_mag;
    logic [ctt_pkg::U_W-1:0]            u_diff;
    logic [ctt_pkg::MPLIER_W-1:0]       w_six;
    logic [ctt_pkg::U_W+1:0]            b_full;
    logic [ctt_pkg::U_W+2:0]            g_full;
    logic [ctt_pkg::U_W+2:0]            g_abs;
    logic signed [PW:0]                 pm_diff;
    logic signed [SW-1:0]               p_sum;
    logic signed [SW-1:0]               c_sum;

    assign accept  = i_in.valid && in_ready;
    assign fin_now = (r_final_time == '0) || (i_in.elapsed_time > r_final_time);
    assign load    = (r_state == ctt_pkg::ST_LOAD) && (!r_ov || o_out.ready);

    // Form the operands of the cubic from the normalised time, and the position and command sums
    always_comb begin
        d_mag   = r_target_ofs[PW-1] ? PW'(-r_target_ofs) : PW'(r_target_ofs);
        u_diff  = r_u - r_u2;
        w_six   = ctt_pkg::MPLIER_W'({u_diff, 2'b00}) + ctt_pkg::MPLIER_W'({u_diff, 1'b0});
        b_full  = (ctt_pkg::U_W+2)'({r_u2, 1'b0}) + (ctt_pkg::U_W+2)'(r_u2)
                - (ctt_pkg::U_W+2)'({r_u3, 1'b0});
        g_full  = G_BASE - ((ctt_pkg::U_W+3)'({r_u, 2'b00}) + (ctt_pkg::U_W+3)'({r_u, 1'b0}));
        g_abs   = g_full[ctt_pkg::U_W+2] ? ((ctt_pkg::U_W+3)'(0) - g_full) : g_full;
        pm_diff = (PW+1)'(r_p) - (PW+1)'(r_m);
        p_sum   = SW'(r_start_pos)
                + SW'($signed(mul_prod[ctt_pkg::U_FRAC+PW:ctt_pkg::U_FRAC]));
        c_sum   = SW'(r_v) + SW'($signed(mul_prod[49:8]));
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctt_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = fin_now ? ctt_pkg::ST_LOAD : ctt_pkg::ST_DIV_U;
                end
            end
            ctt_pkg::ST_DIV_U:  if (div_done) n_state = ctt_pkg::ST_MUL_U2;
            ctt_pkg::ST_MUL_U2: if (mul_done) n_state = ctt_pkg::ST_MUL_U3;
            ctt_pkg::ST_MUL_U3: if (mul_done) n_state = ctt_pkg::ST_MUL_P;
            ctt_pkg::ST_MUL_P:  if (mul_done) n_state = ctt_pkg::ST_MUL_V;
            ctt_pkg::ST_MUL_V:  if (mul_done) n_state = ctt_pkg::ST_DIV_V;
            ctt_pkg::ST_DIV_V:  if (div_done) n_state = ctt_pkg::ST_MUL_TT;
            ctt_pkg::ST_MUL_TT: if (mul_done) n_state = ctt_pkg::ST_MUL_A;
            ctt_pkg::ST_MUL_A:  if (mul_done) n_state = ctt_pkg::ST_DIV_A;
            ctt_pkg::ST_DIV_A:  if (div_done) n_state = ctt_pkg::ST_MUL_C;
            ctt_pkg::ST_MUL_C:  if (mul_done) n_state = ctt_pkg::ST_LOAD;
            ctt_pkg::ST_LOAD:   if (load) n_state = ctt_pkg::ST_IDLE;
            default:            n_state = ctt_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: ready, unit launches and operand selection
    always_comb begin
        in_ready   = 1'b0;
        mul_start  = 1'b0;
        mul_mcand  = '0;
        mul_mplier = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        unique case (r_state)
            ctt_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            ctt_pkg::ST_DIV_U: begin
                div_start = r_go;
                div_num   = ctt_pkg::NUM_W'({r_t, ctt_pkg::U_FRAC'(0)});
                div_den   = ctt_pkg::DEN_W'(r_final_time);
            end
            ctt_pkg::ST_MUL_U2: begin
                mul_start  = r_go;
                mul_mcand  = ctt_pkg::MCAND_W'(r_u);
                mul_mplier = ctt_pkg::MPLIER_W'(r_u);
            end
            ctt_pkg::ST_MUL_U3: begin
                mul_start  = r_go;
                mul_mcand  = ctt_pkg::MCAND_W'(r_u2);
                mul_mplier = ctt_pkg::MPLIER_W'(r_u);
            end
            ctt_pkg::ST_MUL_P: begin
                mul_start  = r_go;
                mul_mcand  = ctt_pkg::MCAND_W'(r_target_ofs);
                mul_mplier = b_full[ctt_pkg::MPLIER_W-1:0];
            end
            ctt_pkg::ST_MUL_V: begin
                mul_start  = r_go;
                mul_mcand  = ctt_pkg::MCAND_W'(d_mag);
                mul_mplier = w_six;
            end
            ctt_pkg::ST_DIV_V: begin
                div_start = r_go;
                div_num   = ctt_pkg::NUM_W'(mul_prod);
                div_den   = ctt_pkg::DEN_W'({r_final_time, 14'd0});
            end
            ctt_pkg::ST_MUL_TT: begin
                mul_start  = r_go;
                mul_mcand  = ctt_pkg::MCAND_W'(r_final_time);
                mul_mplier = ctt_pkg::MPLIER_W'(r_final_time);
            end
            ctt_pkg::ST_MUL_A: begin
                mul_start  = r_go;
                mul_mcand  = ctt_pkg::MCAND_W'(d_mag);
                mul_mplier = g_abs[ctt_pkg::MPLIER_W-1:0];
            end
            ctt_pkg::ST_DIV_A: begin
                div_start = r_go;
                div_num   = {mul_prod[ctt_pkg::NUM_W-4:0], 3'b000};
                div_den   = r_tt;
            end
            ctt_pkg::ST_MUL_C: begin
                mul_start  = r_go;
                mul_mcand  = ctt_pkg::MCAND_W'(pm_diff);
                mul_mplier = ctt_pkg::MPLIER_W'(r_kp);
            end
            ctt_pkg::ST_LOAD: begin
                in_ready = 1'b0;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_in.ready = in_ready;

    // Advance the sequencer; flag the first cycle of every state to launch its unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctt_pkg::ST_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state);
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos  <= '0;
            r_target_ofs <= '0;
            r_final_time <= ctt_pkg::FINAL_TIME_RST;
            r_kp         <= ctt_pkg::KP_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (ctt_pkg::t_cfg_idx'(i_cfg_idx))
                ctt_pkg::CFG_START_POS:  r_start_pos  <= $signed(i_cfg_data);
                ctt_pkg::CFG_TARGET_OFS: r_target_ofs <= $signed(i_cfg_data);
                ctt_pkg::CFG_FINAL_TIME: r_final_time <= i_cfg_data[ctt_pkg::TIME_W-1:0];
                ctt_pkg::CFG_KP_GAIN:    r_kp         <= i_cfg_data[ctt_pkg::KP_W-1:0];
                default:                 r_kp         <= r_kp;
            endcase
        end
    end

    // Capture the request and each unit result as its pass completes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_t   <= i_in.elapsed_time;
            r_m   <= i_in.measured_position;
            r_fin <= fin_now;
        end
        case (r_state)
            ctt_pkg::ST_DIV_U: begin
                if (div_done) r_u <= div_quo[ctt_pkg::U_W-1:0];
            end
            ctt_pkg::ST_MUL_U2: begin
                if (mul_done) r_u2 <= mul_prod[ctt_pkg::U_FRAC+ctt_pkg::U_W-1:ctt_pkg::U_FRAC];
            end
            ctt_pkg::ST_MUL_U3: begin
                if (mul_done) r_u3 <= mul_prod[ctt_pkg::U_FRAC+ctt_pkg::U_W-1:ctt_pkg::U_FRAC];
            end
            ctt_pkg::ST_MUL_P: begin
                if (mul_done) r_p <= sat32(p_sum);
            end
            ctt_pkg::ST_DIV_V: begin
                if (div_done) r_v <= sat_mag(div_quo, div_ovf, r_target_ofs[PW-1]);
            end
            ctt_pkg::ST_MUL_TT: begin
                if (mul_done) r_tt <= mul_prod[ctt_pkg::DEN_W-1:0];
            end
            ctt_pkg::ST_DIV_A: begin
                if (div_done) begin
                    r_a <= sat_mag(div_quo, div_ovf,
                                   r_target_ofs[PW-1] ^ g_full[ctt_pkg::U_W+2]);
                end
            end
            ctt_pkg::ST_MUL_C: begin
                if (mul_done) r_c <= sat32(c_sum);
            end
            default: begin
                r_tt <= r_tt;
            end
        endcase
    end

    // Output register: load a fresh motion result, or repeat the held one when finished
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_o_pos <= '0;
            r_o_vel <= '0;
            r_o_acc <= '0;
            r_o_cmd <= '0;
            r_o_fin <= 1'b0;
        end else if (load) begin
            r_ov    <= 1'b1;
            r_o_fin <= r_fin;
            if (!r_fin) begin
                r_o_pos <= r_p;
                r_o_vel <= r_v;
                r_o_acc <= r_a;
                r_o_cmd <= r_c;
            end
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out.valid                = r_ov;
    assign o_out.planned_position     = r_o_pos;
    assign o_out.planned_velocity     = r_o_vel;
    assign o_out.planned_acceleration = r_o_acc;
    assign o_out.velocity_command     = r_o_cmd;
    assign o_out.finished             = r_o_fin;

    ctt_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    ctt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_ovf   (div_ovf)
    );

endmodule

// ===== rtl/ctt_chk.sv =====
// Port-level checker for the trajectory tracker, bound to the top level.
module ctt_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [ctt_pkg::POS_W-1:0]       i_out_pos,
    input logic [ctt_pkg::POS_W-1:0]       i_out_vel,
    input logic [ctt_pkg::POS_W-1:0]       i_out_acc,
    input logic [ctt_pkg::POS_W-1:0]       i_out_cmd,
    input logic                            i_out_fin
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Keep a stalled result unchanged
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        $stable({i_out_pos, i_out_vel, i_out_acc, i_out_cmd, i_out_fin}))
        else $error("stalled result changed");

    // One request at a time: busy straight after an accepted request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // A new result only appears after the block has been busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result without work");

endmodule

bind cubic_trajectory_tracker ctt_chk u_ctt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_pos   (o_out.planned_position),
    .i_out_vel   (o_out.planned_velocity),
    .i_out_acc   (o_out.planned_acceleration),
    .i_out_cmd   (o_out.velocity_command),
    .i_out_fin   (o_out.finished)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the cubic rest-to-rest trajectory tracker.
`timescale 1ns / 100ps

module tb;

    localparam int      HOLD_CYCLES = 1500;
    localparam int      PHASE_REQS  = 225;
    // Timeout well beyond the slowest correct run, counted in 12 ns clock periods
    localparam longint  TIMEOUT_NS  = 64'd2_500_000 * 12;
    localparam longint  SAT_MAX     = 64'sd2147483647;
    localparam longint  SAT_MIN     = -64'sd2147483648;

    typedef struct {
        logic [ctt_pkg::TIME_W-1:0]       t;
        logic signed [ctt_pkg::POS_W-1:0] m;
    } t_req;

    typedef struct {
        logic signed [ctt_pkg::POS_W-1:0] pos;
        logic signed [ctt_pkg::POS_W-1:0] vel;
        logic signed [ctt_pkg::POS_W-1:0] acc;
        logic signed [ctt_pkg::POS_W-1:0] cmd;
        logic                             fin;
    } t_plan;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    ctt_pkg::t_cfg_idx i_cfg_idx;
    logic [ctt_pkg::POS_W-1:0] i_cfg_data;

    ctt_in_if  in_if ();
    ctt_out_if out_if ();

    cubic_trajectory_tracker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow registers and held outputs of the tracker
    longint cfg_start    = 0;
    longint cfg_offset   = 0;
    longint cfg_duration = longint'(ctt_pkg::FINAL_TIME_RST);
    longint cfg_gain     = longint'(ctt_pkg::KP_GAIN_RST);
    longint held_pos     = 0;
    longint held_vel     = 0;
    longint held_acc     = 0;
    longint held_cmd     = 0;

    t_req  req_q[$];
    t_plan plan_q[$];
    t_req  drv_req;
    t_plan want;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    logic hold_off;
    int n_queued       = 0;
    int n_taken        = 0;
    int n_results      = 0;
    int n_finished     = 0;
    int n_cfg_writes   = 0;
    int n_bad          = 0;

    function automatic longint clamp32(input logic signed [95:0] x);
        if (x > SAT_MAX) return SAT_MAX;
        if (x < SAT_MIN) return SAT_MIN;
        return longint'(x);
    endfunction

    // Plan one tick: evaluate the cubic and the tracking command, or hold when finished
    function automatic t_plan plan_tick(input logic [ctt_pkg::TIME_W-1:0] t_raw,
                                        input logic signed [ctt_pkg::POS_W-1:0] meas);
        longint t, tf, u, u2, u3, blend, offs, g;
        logic signed [95:0] wide;
        t_plan r;
        t  = longint'(t_raw);
        tf = cfg_duration;
        r.fin = (tf == 0) || (t > tf);
        if (!r.fin) begin
            offs  = cfg_offset;
            u     = (t << ctt_pkg::U_FRAC) / tf;
            u2    = (u * u) >>> ctt_pkg::U_FRAC;
            u3    = (u2 * u) >>> ctt_pkg::U_FRAC;
            blend = 3 * u2 - 2 * u3;
            held_pos = clamp32(96'(cfg_start + ((offs * blend) >>> ctt_pkg::U_FRAC)));
            held_vel = clamp32(96'((6 * offs * (u - u2)) / (tf <<< 14)));
            g    = 3 * (longint'(1) << ctt_pkg::U_FRAC) - 6 * u;
            wide = 96'(offs * g);
            wide = (wide * 96'sd8) / 96'(tf * tf);
            held_acc = clamp32(wide);
            held_cmd = clamp32(96'(held_vel + ((cfg_gain * (held_pos - meas)) >>> 8)));
        end
        r.pos = held_pos[ctt_pkg::POS_W-1:0];
        r.vel = held_vel[ctt_pkg::POS_W-1:0];
        r.acc = held_acc[ctt_pkg::POS_W-1:0];
        r.cmd = held_cmd[ctt_pkg::POS_W-1:0];
        return r;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Offer requests from the pending queue, idling at random between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                plan_q.push_back(plan_tick(in_if.elapsed_time, in_if.measured_position));
                n_taken++;
            end
            if (req_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                drv_req = req_q.pop_front();
                in_if.valid             <= 1'b1;
                in_if.elapsed_time      <= drv_req.t;
                in_if.measured_position <= drv_req.m;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Check each result against the oldest plan; stall the output at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (plan_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("result %0d arrived with no request outstanding", n_results);
                end else begin
                    want = plan_q.pop_front();
                    if (want.fin) n_finished++;
                    if (out_if.planned_position !== want.pos ||
                        out_if.planned_velocity !== want.vel ||
                        out_if.planned_acceleration !== want.acc ||
                        out_if.velocity_command !== want.cmd ||
                        out_if.finished !== want.fin) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("result %0d expected pos %0d vel %0d acc %0d cmd %0d fin %0b",
                                     n_results, want.pos, want.vel, want.acc, want.cmd,
                                     want.fin);
                            $display("result %0d actual   pos %0d vel %0d acc %0d cmd %0d fin %0b",
                                     n_results, out_if.planned_position,
                                     out_if.planned_velocity, out_if.planned_acceleration,
                                     out_if.velocity_command, out_if.finished);
                        end
                    end
                end
            end
            out_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold the output off for a long stretch once a motion is streaming in
    initial begin
        hold_off = 1'b0;
        do @(posedge i_clk); while (!(n_taken >= 400 && req_q.size() >= 5));
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Give up after a generous limit
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    task automatic queue_request(input logic [ctt_pkg::TIME_W-1:0] t,
                                 input logic [ctt_pkg::POS_W-1:0] m);
        t_req r;
        r.t = t;
        r.m = m;
        req_q.push_back(r);
        n_queued++;
    endtask

    task automatic set_reg(input ctt_pkg::t_cfg_idx idx, input logic [ctt_pkg::POS_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            ctt_pkg::CFG_START_POS:  cfg_start    = longint'($signed(data));
            ctt_pkg::CFG_TARGET_OFS: cfg_offset   = longint'($signed(data));
            ctt_pkg::CFG_FINAL_TIME: cfg_duration = longint'(data[ctt_pkg::TIME_W-1:0]);
            ctt_pkg::CFG_KP_GAIN:    cfg_gain     = longint'(data[ctt_pkg::KP_W-1:0]);
            default: ;
        endcase
        n_cfg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every request is taken and every result has come back
    task automatic drain();
        while (req_q.size() != 0 || in_if.valid || plan_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write a random mix of registers, extremes included
    task automatic rand_config();
        logic [ctt_pkg::POS_W-1:0] v;
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(3))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                default: v = $urandom;
            endcase
            set_reg(ctt_pkg::CFG_START_POS, v);
        end
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(4))
                0:       v = 32'h7FFF_FFFF;
                1:       v = 32'h8000_0000;
                2:       v = $urandom;
                default: v = $signed($urandom) >>> $urandom_range(8, 24);
            endcase
            set_reg(ctt_pkg::CFG_TARGET_OFS, v);
        end
        if ($urandom_range(3) != 0) begin
            v = $urandom;
            case ($urandom_range(15))
                0:       v[ctt_pkg::TIME_W-1:0] = '0;
                1:       v[ctt_pkg::TIME_W-1:0] = 24'd1;
                2:       v[ctt_pkg::TIME_W-1:0] = 24'hFF_FFFF;
                3:       v[ctt_pkg::TIME_W-1:0] = 24'($urandom_range(2, 255));
                default: v[ctt_pkg::TIME_W-1:0] = 24'($urandom_range(256, 24'h3F_FFFF));
            endcase
            set_reg(ctt_pkg::CFG_FINAL_TIME, v);
        end
        if ($urandom_range(3) != 0) begin
            v = $urandom;
            case ($urandom_range(5))
                0:       v[ctt_pkg::KP_W-1:0] = '0;
                1:       v[ctt_pkg::KP_W-1:0] = 16'hFFFF;
                default: v[ctt_pkg::KP_W-1:0] = 16'($urandom_range(16'hFFFF));
            endcase
            set_reg(ctt_pkg::CFG_KP_GAIN, v);
        end
    endtask

    // Queue one motion: ticks sweeping 0..T then past it, measured near the plan,
    // with some noise requests mixed in
    task automatic rand_motion();
        int n;
        longint tt, mm;
        n = $urandom_range(8, 30);
        for (int k = 0; k <= n + 2; k++) begin
            if ($urandom_range(4) == 0) begin
                queue_request(24'($urandom_range(24'hFF_FFFF)), $urandom);
            end else begin
                if (k <= n) tt = (cfg_duration * k) / n;
                else        tt = cfg_duration + longint'($urandom_range(1, 4096));
                if (tt > 24'hFF_FFFF) tt = 24'hFF_FFFF;
                mm = cfg_start + (cfg_offset * k) / n
                   + longint'($urandom_range(131072)) - 64'sd65536;
                queue_request(tt[ctt_pkg::TIME_W-1:0], mm[ctt_pkg::POS_W-1:0]);
            end
        end
    endtask

    initial begin
        int phase_end;
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_idx               = ctt_pkg::CFG_START_POS;
        i_cfg_data              = '0;
        in_if.valid             = 1'b0;
        in_if.elapsed_time      = '0;
        in_if.measured_position = '0;
        out_if.ready            = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: finished before any motion, then ticks at and below T
        queue_request(24'hFF_FFFF, 32'h7FFF_FFFF);
        queue_request(24'h01_0001, 32'h0);
        queue_request(24'h01_0000, 32'h8000_0000);
        queue_request(24'h0, 32'h0);
        drain();

        // Largest positive motion over the longest duration, full gain
        set_reg(ctt_pkg::CFG_START_POS, 32'h7FFF_FFFF);
        set_reg(ctt_pkg::CFG_TARGET_OFS, 32'h7FFF_FFFF);
        set_reg(ctt_pkg::CFG_FINAL_TIME, 32'hFFFF_FFFF);
        set_reg(ctt_pkg::CFG_KP_GAIN, 32'hFFFF_FFFF);
        queue_request(24'h0, 32'h8000_0000);
        queue_request(24'h7F_FFFF, 32'h0);
        queue_request(24'hFF_FFFF, 32'h8000_0000);
        drain();

        // Largest negative motion over the shortest duration, zero gain
        set_reg(ctt_pkg::CFG_START_POS, 32'h8000_0000);
        set_reg(ctt_pkg::CFG_TARGET_OFS, 32'h8000_0000);
        set_reg(ctt_pkg::CFG_FINAL_TIME, 32'h0000_0001);
        set_reg(ctt_pkg::CFG_KP_GAIN, 32'h0);
        queue_request(24'h0, 32'h7FFF_FFFF);
        queue_request(24'h1, 32'h7FFF_FFFF);
        queue_request(24'h2, 32'h0);
        queue_request(24'hFF_FFFF, 32'h1234_5678);
        drain();

        // A register write leaves the held outputs alone
        set_reg(ctt_pkg::CFG_START_POS, 32'h0);
        queue_request(24'h5, 32'h0);
        drain();

        // Zero duration is always finished
        set_reg(ctt_pkg::CFG_FINAL_TIME, 32'h0);
        queue_request(24'h0, 32'h0);
        queue_request(24'hFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // One second, ten units of travel, unit gain
        set_reg(ctt_pkg::CFG_FINAL_TIME, 32'h0001_0000);
        set_reg(ctt_pkg::CFG_TARGET_OFS, 32'h000A_0000);
        set_reg(ctt_pkg::CFG_KP_GAIN, 32'h0000_0100);
        for (int k = 0; k <= 4; k++)
            queue_request(24'(k * 16384), $urandom);
        drain();

        // Random motions under each idling pattern
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_gap_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_stall_pct = 49; end
                default: begin send_gap_pct = 29; recv_stall_pct = 29; end
            endcase
            phase_end = n_queued + PHASE_REQS;
            while (n_queued < phase_end) begin
                rand_config();
                rand_motion();
                drain();
            end
        end

        // Let any stray result show up
        repeat (400) @(posedge i_clk);
        $display("Covered %0d ticks (%0d finished), %0d register writes, extremes included",
                 n_taken, n_finished, n_cfg_writes);
        $display("Traffic: free, input gaps, output stalls, both, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (n_bad == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
